FILE: sv/assert_macros.svh
// Assertion macros used by the signed integer to decimal ASCII RTL.
// Include this file by its bare name. No other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define SIDTA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("sidta assertion failed");
// Check a property on every clock edge, reset included.
`define SIDTA_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("sidta assertion failed");
`else
`define SIDTA_ASSERT(lbl, prop)
`define SIDTA_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: sv/sidta_pkg.sv
// Types and constants for the signed integer to decimal ASCII converter.
// No dependencies.
package sidta_pkg;

    localparam int VALUE_W      = 32;
    localparam int NUM_DIGITS   = 10;
    localparam int BCD_W        = 4 * NUM_DIGITS;
    localparam int DD_STEPS     = 4;                   // binary bits consumed per stage
    localparam int DD_STAGES    = VALUE_W / DD_STEPS;
    localparam int CHAR_W       = 8;
    localparam int COUNT_W      = 4;
    localparam int IDX_W        = 4;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'h2D;
    localparam logic [COUNT_W-1:0] MAX_CHARS   = 4'd11;

    // Word carried down the double-dabble pipeline
    typedef struct packed {
        logic               neg;
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } t_dd_word;

endpackage

FILE: sv/sidta_dd_stage.sv
// One register stage of the double-dabble binary to BCD pipeline.
// Depends on sidta_pkg.
module sidta_dd_stage
    import sidta_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dd_word i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_dd_word o_data
);

    logic     r_valid;
    t_dd_word r_data;
    t_dd_word n_data;

    // For each of the DD_STEPS bits: add three to every digit of five or more, then shift in one binary bit
    always_comb begin
        n_data = i_data;
        for (int s = 0; s < DD_STEPS; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (n_data.bcd[4*d +: 4] >= 4'd5) begin
                    n_data.bcd[4*d +: 4] = n_data.bcd[4*d +: 4] + 4'd3;
                end
            end
            n_data.bcd = {n_data.bcd[BCD_W-2:0], n_data.bin[VALUE_W-1]};
            n_data.bin = {n_data.bin[VALUE_W-2:0], 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: sv/sidta_serializer.sv
// Character serializer: turns a BCD word and sign into one ASCII character per request.
// Depends on sidta_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sidta_serializer
    import sidta_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_dd_word           i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CHAR_W-1:0]  o_char,
    output logic [COUNT_W-1:0] o_count,
    output logic               o_last
);

    logic               r_busy;
    logic               r_sign_pend;
    logic [IDX_W-1:0]   r_idx;
    logic [BCD_W-1:0]   r_bcd;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_last;

    logic               out_free;
    logic               emit;
    logic               emit_last;
    logic [3:0]         digit;
    logic [CHAR_W-1:0]  emit_char;
    logic               load;
    logic [IDX_W-1:0]   ndig;

    assign out_free  = !r_out_valid || i_ready;
    assign emit      = r_busy && out_free;
    assign emit_last = !r_sign_pend && (r_idx == '0);
    assign digit     = r_bcd[{r_idx, 2'b00} +: 4];
    assign emit_char = r_sign_pend ? ASCII_MINUS : (ASCII_ZERO + {4'b0000, digit});
    assign o_ready   = !r_busy || (emit && emit_last);
    assign load      = i_valid && o_ready;

    // Count significant digits; zero still counts as one digit
    always_comb begin
        ndig = 4'd1;
        for (int d = 1; d < NUM_DIGITS; d++) begin
            if (i_data.bcd[4*d +: 4] != 4'd0) begin
                ndig = IDX_W'(d + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_sign_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_busy      <= 1'b1;
                r_sign_pend <= i_data.neg;
            end else if (emit) begin
                if (r_sign_pend) begin
                    r_sign_pend <= 1'b0;
                end else if (r_idx == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char  <= emit_char;
            r_out_count <= r_count;
            r_out_last  <= emit_last;
        end
        if (load) begin
            r_idx   <= ndig - 4'd1;
            r_bcd   <= i_data.bcd;
            r_count <= ndig + {3'b000, i_data.neg};
        end else if (emit && !r_sign_pend && (r_idx != '0)) begin
            r_idx <= r_idx - 4'd1;
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_count = r_out_count;
    assign o_last  = r_out_last;

    `SIDTA_ASSERT(a_idx_range, r_busy |-> (r_idx < IDX_W'(NUM_DIGITS)))
    `SIDTA_ASSERT(a_sign_busy, r_sign_pend |-> r_busy)
    `SIDTA_ASSERT(a_minus_not_last, (r_out_valid && (r_out_char == ASCII_MINUS)) |-> !r_out_last)
    `SIDTA_ASSERT(a_count_range, r_out_valid |-> ((r_out_count >= 4'd1) && (r_out_count <= MAX_CHARS)))
    `SIDTA_ASSERT(a_last_frees, (emit && emit_last && !load) |=> !r_busy)

endmodule

FILE: sv/signed_int_to_decimal_ascii_core.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on sidta_pkg, sidta_dd_stage and sidta_serializer.

// Each request on the slave stream carries one two's complement 32-bit value; the master
// stream returns its decimal text one ASCII character per request, most significant first,
// a leading '-' for negative values, no leading zeros, and '0' alone for zero. Every
// character carries the total character count (1 to 11) and tlast marks the final one.
// The value passes through an input register that forms the sign and unsigned magnitude
// (so -2147483648 converts correctly), then eight double-dabble stages that each consume
// four magnitude bits, then the serializer and its output register. The pipeline takes a new
// value every cycle while it has room, but the serializer drives one character per cycle
// while the master side accepts, so each value holds it for one request per character
// (1 to 11 characters, 11 in the worst case). The serializer takes the next value in the
// same cycle it emits the last character of the current one, so back-to-back values leave
// without gaps. Backpressure on the master side stalls the whole chain without losing or
// repeating anything. No state survives between values.
module signed_int_to_decimal_ascii_core
    import sidta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] character, [11:8] char_count, [15:12] zero
    output logic        o_m_tlast    // last_char
);

    // Input register: sign and magnitude
    logic     r_in_valid;
    t_dd_word r_in_data;
    t_dd_word n_in_data;
    logic     in_ready;

    // Handshake and data between the double-dabble stages
    logic     stg_valid [DD_STAGES+1];
    logic     stg_ready [DD_STAGES+1];
    t_dd_word stg_data  [DD_STAGES+1];

    logic [CHAR_W-1:0]  out_char;
    logic [COUNT_W-1:0] out_count;

    // Take the magnitude as unsigned so the most negative value needs no extra bit
    always_comb begin
        n_in_data.neg = i_s_tdata[VALUE_W-1];
        n_in_data.bin = i_s_tdata[VALUE_W-1] ? (32'd0 - i_s_tdata) : i_s_tdata;
        n_in_data.bcd = '0;
    end

    assign in_ready   = !r_in_valid || stg_ready[0];
    assign o_s_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_tvalid) begin
            r_in_data <= n_in_data;
        end
    end

    assign stg_valid[0] = r_in_valid;
    assign stg_data[0]  = r_in_data;

    // Eight stages, four binary bits each
    for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
        sidta_dd_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_data  (stg_data[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_data  (stg_data[g+1])
        );
    end

    // Serializer: one character per cycle while the master side accepts, output register toward the master side
    sidta_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[DD_STAGES]),
        .o_ready (stg_ready[DD_STAGES]),
        .i_data  (stg_data[DD_STAGES]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_char  (out_char),
        .o_count (out_count),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {4'b0000, out_count, out_char};

endmodule

FILE: dv/signed_int_to_decimal_ascii_core_tb.sv
// Self-checking testbench for signed_int_to_decimal_ascii_core: directed table, then random
// values, with an independent decimal-text predictor and random stalls on both streams.
// Depends on sidta_pkg and the core RTL only.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_core_tb
    import sidta_pkg::*;
();

    localparam int N_DIRECTED  = 20;
    localparam int N_RANDOM    = 300;
    localparam int LONG_HOLD   = 400;   // receiver hold-off, in cycles
    localparam int IDLE_LIMIT  = 3000;  // cycles with no request moving on either side
    localparam int DRAIN_WAIT  = 40;

    // One ASCII character as it should leave the master side
    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_char_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;   // [31:0] value
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;        // [7:0] character, [11:8] char_count, [15:12] zero
    logic        o_m_tlast;        // last_char

    t_char_beat  pending_chars [$];
    int          error_count = 0;
    int          values_taken = 0;
    bit          quiet_stretch = 1'b0;
    bit          hold_done = 1'b0;

    // Directed table: an empty text means "let the predictor decide"
    logic [31:0] dir_value [N_DIRECTED] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'd1000000000, -32'sd1000000000,
        32'd999999999, 32'h5555_5555, 32'hAAAA_AAAA, 32'd123456789, -32'sd987654321,
        32'h7FFF_FFFE
    };
    string dir_text [N_DIRECTED] = '{
        "0", "1", "-1", "9", "-9", "10", "", "", "",
        "2147483647", "-2147483647", "-2147483648", "1000000000", "",
        "", "", "", "", "",
        ""
    };

    signed_int_to_decimal_ascii_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Count a mismatch and print one line about it
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("[%0t] mismatch: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    // Mostly no gap or a short one, a few long ones, none at all during a quiet stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_stretch || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Work out the decimal text of a two's complement value and queue its characters:
    // sign first when negative, then digits most significant first, no leading zeros.
    function automatic void predict_decimal_text(input logic [31:0] value);
        logic               neg;
        logic [31:0]        mag;
        logic [3:0]         digit [NUM_DIGITS];
        int                 n_digits;
        logic [COUNT_W-1:0] total;
        t_char_beat         beat;
        neg = value[31];
        // the unsigned magnitude also covers the most negative value
        mag = neg ? (~value + 32'd1) : value;
        n_digits = 0;
        do begin
            digit[n_digits] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            n_digits++;
        end while (mag != 0);
        total = COUNT_W'(n_digits + int'(neg));
        if (neg) begin
            beat = '{ch: ASCII_MINUS, count: total, last: 1'b0};
            pending_chars.push_back(beat);
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            beat = '{ch: ASCII_ZERO + CHAR_W'(digit[i]), count: total, last: (i == 0)};
            pending_chars.push_back(beat);
        end
    endfunction

    // Queue characters typed straight from a text
    function automatic void queue_text(input string text);
        t_char_beat beat;
        for (int i = 0; i < text.len(); i++) begin
            beat = '{ch: text[i], count: COUNT_W'(text.len()), last: (i == text.len() - 1)};
            pending_chars.push_back(beat);
        end
    endfunction

    // Random value: mostly a chosen digit count with random sign, sometimes any 32 bits
    function automatic logic [31:0] random_value();
        int          n_digits;
        int unsigned p;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] v;
        if ($urandom_range(0, 9) < 2)
            return $urandom();
        n_digits = $urandom_range(1, 10);
        p = 1;
        repeat (n_digits - 1) p = p * 10;
        lo = (n_digits == 1) ? 32'd0 : p;
        hi = (n_digits == 10) ? 32'h7FFF_FFFF : p * 10 - 1;
        v = $urandom_range(hi, lo);
        if ($urandom_range(0, 1))
            v = ~v + 32'd1;
        return v;
    endfunction

    // Offer one value and hold it until the core takes the request; expectations are
    // queued at the accepting edge. tvalid is only lowered when a gap follows, so a
    // back-to-back request keeps it high without a second assignment in the same step.
    task automatic send_value(input logic [31:0] value, input string text);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        do @(posedge i_clk); while (!o_s_tready);
        if (text.len() > 0)
            queue_text(text);
        else
            predict_decimal_text(value);
        values_taken++;
        quiet_stretch = ((values_taken / 50) % 3 == 2);
    endtask

    // Sender: reset, directed table, random values, drain, verdict
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < N_DIRECTED; i++)
            send_value(dir_value[i], dir_text[i]);
        for (int i = 0; i < N_RANDOM; i++)
            send_value(random_value(), "");
        i_s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0)
            $display("** signed_int_to_decimal_ascii_core: PASSED **");
        else
            $display("** signed_int_to_decimal_ascii_core: FAILED **");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off once the run is under way so the
    // pipeline fills and backs up into the slave side while the sender keeps offering.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if (!hold_done && values_taken >= 80) begin
                hold_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
        end
    end

    // Compare each accepted character with the oldest expectation
    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected character", int'(o_m_tdata), 0);
            end else begin
                want = pending_chars.pop_front();
                if (o_m_tdata[7:0] !== want.ch)
                    report_mismatch("character", int'(o_m_tdata[7:0]), int'(want.ch));
                if (o_m_tdata[11:8] !== want.count)
                    report_mismatch("char_count", int'(o_m_tdata[11:8]), int'(want.count));
                if (o_m_tdata[15:12] !== 4'd0)
                    report_mismatch("tdata pad", int'(o_m_tdata[15:12]), 0);
                if (o_m_tlast !== want.last)
                    report_mismatch("tlast", int'(o_m_tlast), int'(want.last));
            end
        end
    end

    // Watchdog: end the run when no request moves on either side for too long
    initial begin
        int idle;
        idle = 0;
        do begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle = 0;
            else
                idle++;
        end while (idle < IDLE_LIMIT);
        $display("[%0t] timeout: no request moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("** signed_int_to_decimal_ascii_core: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/sidta_pkg.sv
sv/sidta_dd_stage.sv
sv/sidta_serializer.sv
sv/signed_int_to_decimal_ascii_core.sv
dv/signed_int_to_decimal_ascii_core_tb.sv
